>>> src/efrs_pkg.sv
// ----------------------------------------------------------------------------
// efrs_pkg
// Shared types, codes and constants of the earliest-fit resource scheduler.
// ----------------------------------------------------------------------------
package efrs_pkg;

  localparam int NUM_PERIODS_DEF = 256;
  localparam int START_LIMIT     = 256;

  localparam int IDX_W   = 8;
  localparam int CAP_W   = 16;
  localparam int NEED_W  = 16;
  localparam int DUR_W   = 8;
  localparam int USAGE_W = 24;
  localparam int START_W = 8;
  localparam int END_W   = 9;

  localparam logic [USAGE_W-1:0] USAGE_MAX = '1;

  // input tdata: period_index, capacity_value, required_resource, recovery_time, first_job
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_CAP_LSB   = IN_IDX_LSB + IDX_W;
  localparam int IN_NEED_LSB  = IN_CAP_LSB + CAP_W;
  localparam int IN_DUR_LSB   = IN_NEED_LSB + NEED_W;
  localparam int IN_FIRST_LSB = IN_DUR_LSB + DUR_W;
  localparam int IN_BITS      = IN_FIRST_LSB + 1;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // output tdata: start_period, end_period, found
  localparam int OUT_START_LSB = 0;
  localparam int OUT_END_LSB   = OUT_START_LSB + START_W;
  localparam int OUT_FOUND_LSB = OUT_END_LSB + END_W;
  localparam int OUT_BITS      = OUT_FOUND_LSB + 1;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic FUNC_CAP = 1'b0;
  localparam logic FUNC_JOB = 1'b1;

  // walker modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_FILL = 2'd1;
  localparam logic [1:0] MODE_SRCH = 2'd2;
  localparam logic [1:0] MODE_BOOK = 2'd3;

  typedef struct packed {
    logic       cap_wr;
    logic       job_ld;
    logic       walk_go;
    logic [1:0] walk_mode;
    logic       clr_only;
    logic       out_ld;
  } efrs_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic found;
    logic first;
    logic out_free;
  } efrs_sts_t;

endpackage

>>> src/efrs_ctrl.sv
// ----------------------------------------------------------------------------
// efrs_ctrl
// Controller: usage clearing, first-job fill, search, booking and result load.
// ----------------------------------------------------------------------------
module efrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_func,
  output logic                in_tready,
  input  efrs_pkg::efrs_sts_t sts,
  output efrs_pkg::efrs_cmd_t cmd
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_IDLE  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_SRCH  = 3'd5;
  localparam logic [2:0] S_BOOK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.walk_mode = efrs_pkg::MODE_NONE;
    unique case (state_r)
      S_INIT: begin
        // sweep zeros through the whole usage store
        cmd.walk_go   = 1'b1;
        cmd.walk_mode = efrs_pkg::MODE_FILL;
        cmd.clr_only  = 1'b1;
        state_nxt     = S_CLR;
      end
      S_CLR: begin
        if (sts.walk_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (in_func == efrs_pkg::FUNC_CAP) begin
            cmd.cap_wr = 1'b1;
          end else begin
            cmd.job_ld = 1'b1;
            state_nxt  = S_START;
          end
        end
      end
      S_START: begin
        cmd.walk_go = 1'b1;
        if (sts.first) begin
          cmd.walk_mode = efrs_pkg::MODE_FILL;
          state_nxt     = S_FILL;
        end else begin
          cmd.walk_mode = efrs_pkg::MODE_SRCH;
          state_nxt     = S_SRCH;
        end
      end
      S_FILL: begin
        if (sts.walk_done) state_nxt = S_OUT;
      end
      S_SRCH: begin
        if (sts.walk_done) begin
          if (sts.found) begin
            cmd.walk_go   = 1'b1;
            cmd.walk_mode = efrs_pkg::MODE_BOOK;
            state_nxt     = S_BOOK;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_BOOK: begin
        if (sts.walk_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/efrs_dp.sv
// ----------------------------------------------------------------------------
// efrs_dp
// Datapath: capacity and usage stores, address walker, fit compare,
// saturating booking and the output register.
// ----------------------------------------------------------------------------
module efrs_dp #(
  parameter int NUM_PERIODS = efrs_pkg::NUM_PERIODS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [efrs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  efrs_pkg::efrs_cmd_t                 cmd,
  output efrs_pkg::efrs_sts_t                 sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [efrs_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int AW = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
  localparam int CW = AW + 1;
  localparam int EW = (CW > efrs_pkg::END_W) ? CW : efrs_pkg::END_W;
  localparam int SRCH_LIM = (NUM_PERIODS < efrs_pkg::START_LIMIT) ?
                            NUM_PERIODS : efrs_pkg::START_LIMIT;
  localparam logic [EW-1:0] NP_E   = EW'(NUM_PERIODS);
  localparam logic [CW-1:0] NP_C   = CW'(NUM_PERIODS);
  localparam logic [CW-1:0] SLIM_C = CW'(SRCH_LIM);

  // input fields
  logic [efrs_pkg::IDX_W-1:0]  f_idx;
  logic [efrs_pkg::CAP_W-1:0]  f_cap;
  logic [efrs_pkg::NEED_W-1:0] f_need;
  logic [efrs_pkg::DUR_W-1:0]  f_dur;
  logic                        f_first;

  assign f_idx   = in_tdata[efrs_pkg::IN_IDX_LSB  +: efrs_pkg::IDX_W];
  assign f_cap   = in_tdata[efrs_pkg::IN_CAP_LSB  +: efrs_pkg::CAP_W];
  assign f_need  = in_tdata[efrs_pkg::IN_NEED_LSB +: efrs_pkg::NEED_W];
  assign f_dur   = in_tdata[efrs_pkg::IN_DUR_LSB  +: efrs_pkg::DUR_W];
  assign f_first = in_tdata[efrs_pkg::IN_FIRST_LSB];

  // stores
  logic [efrs_pkg::USAGE_W-1:0] usage_mem [NUM_PERIODS];
  logic [efrs_pkg::CAP_W-1:0]   cap_mem   [NUM_PERIODS];
  logic [efrs_pkg::USAGE_W-1:0] u_rd_r;
  logic [efrs_pkg::CAP_W-1:0]   c_rd_r;

  // job registers
  logic [efrs_pkg::NEED_W-1:0]  need_r;
  logic [efrs_pkg::DUR_W-1:0]   dur_r;
  logic                         first_r;
  logic [efrs_pkg::START_W-1:0] start_r;
  logic                         found_r;

  // walker
  logic [1:0]    mode_r;
  logic [CW-1:0] addr_r;
  logic [CW-1:0] lim_r;
  logic [CW-1:0] fill_lim_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;

  // output register
  logic                         out_vld_r;
  logic [efrs_pkg::START_W-1:0] out_start_r;
  logic [efrs_pkg::END_W-1:0]   out_end_r;
  logic                         out_found_r;

  logic                          fits;
  logic                          hit;
  logic                          issue;
  logic                          rd_issue;
  logic [efrs_pkg::USAGE_W:0]    sum_fit;
  logic [efrs_pkg::USAGE_W:0]    sum_book;
  logic [efrs_pkg::USAGE_W-1:0]  book_val;
  logic                          u_we;
  logic [AW-1:0]                 u_wa;
  logic [efrs_pkg::USAGE_W-1:0]  u_wd;
  logic [EW-1:0]                 idx_e;
  logic                          cap_we;
  logic [efrs_pkg::END_W-1:0]    end_sum;
  logic [EW-1:0]                 end_e;
  logic [EW-1:0]                 dur_e;
  logic [EW-1:0]                 start_e;
  logic [EW-1:0]                 rd_idx_e;
  logic [CW-1:0]                 book_lim;
  logic [CW-1:0]                 fill_lim;

  assign sum_fit  = {1'b0, u_rd_r} + (efrs_pkg::USAGE_W+1)'(need_r);
  assign fits     = sum_fit <= (efrs_pkg::USAGE_W+1)'(c_rd_r);
  assign hit      = rd_vld_r && (mode_r == efrs_pkg::MODE_SRCH) && fits && !found_r;

  assign sum_book = {1'b0, u_rd_r} + (efrs_pkg::USAGE_W+1)'(need_r);
  assign book_val = sum_book[efrs_pkg::USAGE_W] ? efrs_pkg::USAGE_MAX :
                    sum_book[efrs_pkg::USAGE_W-1:0];

  // stop issuing once the search has a hit
  assign issue    = (mode_r != efrs_pkg::MODE_NONE) && (addr_r < lim_r) &&
                    !((mode_r == efrs_pkg::MODE_SRCH) && (found_r || hit));
  assign rd_issue = issue && ((mode_r == efrs_pkg::MODE_SRCH) ||
                              (mode_r == efrs_pkg::MODE_BOOK));

  always_comb begin
    u_we = 1'b0;
    u_wa = addr_r[AW-1:0];
    u_wd = '0;
    if (issue && (mode_r == efrs_pkg::MODE_FILL)) begin
      u_we = 1'b1;
      u_wd = (addr_r < fill_lim_r) ? (efrs_pkg::USAGE_W)'(need_r) : '0;
    end else if (rd_vld_r && (mode_r == efrs_pkg::MODE_BOOK)) begin
      u_we = 1'b1;
      u_wa = rd_idx_r;
      u_wd = book_val;
    end
  end

  assign idx_e  = EW'(f_idx);
  assign cap_we = cmd.cap_wr && (idx_e < NP_E);

  assign end_sum  = {1'b0, start_r} + {1'b0, dur_r};
  assign end_e    = EW'(end_sum);
  assign dur_e    = EW'(dur_r);
  assign start_e  = EW'(start_r);
  assign rd_idx_e = EW'(rd_idx_r);
  assign book_lim = (end_e < NP_E) ? end_e[CW-1:0] : NP_C;
  assign fill_lim = (dur_e < NP_E) ? dur_e[CW-1:0] : NP_C;

  always_ff @(posedge clk) begin
    if (u_we) usage_mem[u_wa] <= u_wd;
    if (rd_issue) u_rd_r <= usage_mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cap_we) cap_mem[idx_e[AW-1:0]] <= f_cap;
    if (rd_issue) c_rd_r <= cap_mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.job_ld) begin
      need_r  <= f_need;
      dur_r   <= f_dur;
      first_r <= f_first;
    end
    if (rd_issue) rd_idx_r <= addr_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= efrs_pkg::MODE_NONE;
      addr_r     <= '0;
      lim_r      <= '0;
      fill_lim_r <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      start_r    <= '0;
    end else begin
      rd_vld_r <= rd_issue;
      if (issue) addr_r <= addr_r + CW'(1);
      if (hit) begin
        found_r <= 1'b1;
        start_r <= rd_idx_e[efrs_pkg::START_W-1:0];
      end
      if (cmd.job_ld) begin
        found_r <= 1'b0;
        start_r <= '0;
      end
      if (cmd.walk_go) begin
        mode_r <= cmd.walk_mode;
        unique case (cmd.walk_mode)
          efrs_pkg::MODE_FILL: begin
            addr_r     <= '0;
            lim_r      <= NP_C;
            fill_lim_r <= cmd.clr_only ? '0 : fill_lim;
            if (!cmd.clr_only) begin
              found_r <= 1'b1;
              start_r <= '0;
            end
          end
          efrs_pkg::MODE_SRCH: begin
            addr_r <= '0;
            lim_r  <= SLIM_C;
          end
          efrs_pkg::MODE_BOOK: begin
            addr_r <= start_e[CW-1:0];
            lim_r  <= book_lim;
          end
          default: begin
            addr_r <= '0;
            lim_r  <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_found_r <= found_r;
      out_start_r <= found_r ? start_r : '0;
      out_end_r   <= found_r ? end_sum : '0;
    end
  end

  assign sts.walk_done = ((addr_r >= lim_r) ||
                          ((mode_r == efrs_pkg::MODE_SRCH) && found_r)) && !rd_vld_r;
  assign sts.found     = found_r;
  assign sts.first     = first_r;
  assign sts.out_free  = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[efrs_pkg::OUT_START_LSB +: efrs_pkg::START_W] = out_start_r;
    out_tdata[efrs_pkg::OUT_END_LSB   +: efrs_pkg::END_W]   = out_end_r;
    out_tdata[efrs_pkg::OUT_FOUND_LSB]                      = out_found_r;
  end

endmodule

>>> src/earliest_fit_resource_scheduler_unit.sv
// Throughput: one capacity load per cycle; a job holds off requests until its result loads.
// A first job runs a fill pass over the usage store: its need below its duration, zero above.
// A later job searches up to min(NUM_PERIODS, 256) periods for a fit, then, if one is found,
// books min(duration, NUM_PERIODS - start) periods of usage, one period per cycle.
// Reset: synchronous; after it a clearing pass zeroes usage while no request is taken.
// ----------------------------------------------------------------------------
// earliest_fit_resource_scheduler_unit
// Earliest-fit serial schedule builder over a per-period capacity profile.
// ----------------------------------------------------------------------------
module earliest_fit_resource_scheduler_unit #(
  parameter int NUM_PERIODS = efrs_pkg::NUM_PERIODS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // period_index, capacity_value, required_resource, recovery_time, first_job
  input  logic [efrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // start_period, end_period, found
  output logic [efrs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  efrs_pkg::efrs_cmd_t cmd;
  efrs_pkg::efrs_sts_t sts;

  efrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  efrs_dp #(
    .NUM_PERIODS (NUM_PERIODS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // no fit reports zero start and end
  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[efrs_pkg::OUT_FOUND_LSB]) |->
    (out_tdata[efrs_pkg::OUT_FOUND_LSB-1:0] == '0))
    else $error("no-fit result with nonzero periods");

  a_end_ge_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
    (out_tdata[efrs_pkg::OUT_END_LSB +: efrs_pkg::END_W] >=
     {1'b0, out_tdata[efrs_pkg::OUT_START_LSB +: efrs_pkg::START_W]}))
    else $error("end period below start period");

  // a job request blocks further requests until its result is built
  a_job_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == efrs_pkg::FUNC_JOB)) |=> !in_tready)
    else $error("request taken while a job is in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("request taken before the usage clear pass");

endmodule

>>> verif/scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scheduler_checker
// Watches both streams of the earliest-fit scheduler, keeps its own capacity
// and usage profiles, predicts the placement of every job request and
// compares each returned placement field by field in arrival order.
// ----------------------------------------------------------------------------
module scheduler_checker #(
  parameter int PERIODS = efrs_pkg::NUM_PERIODS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [efrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [efrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                               mismatches,
  output int                               awaiting
);

  localparam int DUE_DEPTH = 16;

  typedef struct packed {
    logic [efrs_pkg::START_W-1:0] start;
    logic [efrs_pkg::END_W-1:0]   stop;
    logic                         found;
  } placement_t;

  logic [efrs_pkg::USAGE_W-1:0] usage_prof [PERIODS];
  logic [efrs_pkg::CAP_W-1:0]   cap_prof   [PERIODS];
  placement_t                   due_fifo   [DUE_DEPTH];
  int                           due_wr;
  int                           due_rd;

  initial begin
    mismatches = 0;
    awaiting   = 0;
    due_wr     = 0;
    due_rd     = 0;
    foreach (cap_prof[t]) cap_prof[t] = '0;
    foreach (usage_prof[t]) usage_prof[t] = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_usage();
    foreach (usage_prof[t]) usage_prof[t] = '0;
  endfunction

  // Earliest fit in window, or start 0 if first; then book need over [start, end)
  function automatic placement_t plan_placement(input logic [efrs_pkg::NEED_W-1:0] need,
                                                input logic [efrs_pkg::DUR_W-1:0] dur,
                                                input logic first);
    placement_t                 p;
    int                         t;
    int                         lim;
    logic [efrs_pkg::USAGE_W:0] sum;
    p = '0;
    lim = (PERIODS < efrs_pkg::START_LIMIT) ? PERIODS : efrs_pkg::START_LIMIT;
    if (first) begin
      clear_usage();
      p.found = 1'b1;
    end else begin
      t = 0;
      while (!p.found && t < lim) begin
        sum = {1'b0, usage_prof[t]} + (efrs_pkg::USAGE_W+1)'(need);
        if (sum <= (efrs_pkg::USAGE_W+1)'(cap_prof[t])) begin
          p.start = (efrs_pkg::START_W)'(t);
          p.found = 1'b1;
        end
        t++;
      end
    end
    if (p.found) begin
      p.stop = {1'b0, p.start} + {1'b0, dur};
      for (t = int'(p.start); t < int'(p.stop) && t < PERIODS; t++) begin
        sum = {1'b0, usage_prof[t]} + (efrs_pkg::USAGE_W+1)'(need);
        usage_prof[t] = sum[efrs_pkg::USAGE_W] ? efrs_pkg::USAGE_MAX :
                        sum[efrs_pkg::USAGE_W-1:0];
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    placement_t                 want;
    placement_t                 got;
    logic [efrs_pkg::IDX_W-1:0] idx;
    if (!rst_n) begin
      clear_usage();
      due_wr = 0;
      due_rd = 0;
    end else begin
      // retire the returned placement first; a request taken now cannot answer yet
      if (out_tvalid && out_tready) begin
        got.start = out_tdata[efrs_pkg::OUT_START_LSB +: efrs_pkg::START_W];
        got.stop  = out_tdata[efrs_pkg::OUT_END_LSB +: efrs_pkg::END_W];
        got.found = out_tdata[efrs_pkg::OUT_FOUND_LSB];
        if (due_wr == due_rd) begin
          report_mismatch($sformatf("placement with none pending: start %0d end %0d found %0b",
                                    got.start, got.stop, got.found));
        end else begin
          want = due_fifo[due_rd % DUE_DEPTH];
          due_rd++;
          if (got.start !== want.start)
            report_mismatch($sformatf("start_period %0d, predicted %0d", got.start, want.start));
          if (got.stop !== want.stop)
            report_mismatch($sformatf("end_period %0d, predicted %0d", got.stop, want.stop));
          if (got.found !== want.found)
            report_mismatch($sformatf("found %0b, predicted %0b", got.found, want.found));
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == efrs_pkg::FUNC_CAP) begin
          idx = in_tdata[efrs_pkg::IN_IDX_LSB +: efrs_pkg::IDX_W];
          if (idx < PERIODS) cap_prof[idx] = in_tdata[efrs_pkg::IN_CAP_LSB +: efrs_pkg::CAP_W];
        end else begin
          if (due_wr - due_rd >= DUE_DEPTH)
            report_mismatch("job requests taken far ahead of their placements");
          due_fifo[due_wr % DUE_DEPTH] =
            plan_placement(in_tdata[efrs_pkg::IN_NEED_LSB +: efrs_pkg::NEED_W],
                           in_tdata[efrs_pkg::IN_DUR_LSB +: efrs_pkg::DUR_W],
                           in_tdata[efrs_pkg::IN_FIRST_LSB]);
          due_wr++;
        end
      end
    end
    awaiting = due_wr - due_rd;
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives capacity and job requests into the earliest-fit scheduler: a full
// capacity load, a directed pass over the corner cases, then random schedules
// with random idling on both streams. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PERIODS     = efrs_pkg::NUM_PERIODS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN       = 2 * PERIODS + 64;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [efrs_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [efrs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             calm       = 1'b0;
  int                               mismatches;
  int                               awaiting;
  int unsigned                      cycle_count = 0;

  always #1 clk = ~clk;

  earliest_fit_resource_scheduler_unit #(.NUM_PERIODS(PERIODS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  scheduler_checker #(.PERIODS(PERIODS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [efrs_pkg::IN_TDATA_W-1:0] pack_req(
      input logic [efrs_pkg::IDX_W-1:0] idx, input logic [efrs_pkg::CAP_W-1:0] cap,
      input logic [efrs_pkg::NEED_W-1:0] need, input logic [efrs_pkg::DUR_W-1:0] dur,
      input logic first);
    logic [efrs_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[efrs_pkg::IN_IDX_LSB +: efrs_pkg::IDX_W]   = idx;
    d[efrs_pkg::IN_CAP_LSB +: efrs_pkg::CAP_W]   = cap;
    d[efrs_pkg::IN_NEED_LSB +: efrs_pkg::NEED_W] = need;
    d[efrs_pkg::IN_DUR_LSB +: efrs_pkg::DUR_W]   = dur;
    d[efrs_pkg::IN_FIRST_LSB]                    = first;
    return d;
  endfunction

  function automatic logic [efrs_pkg::NEED_W-1:0] pick_need();
    case ($urandom_range(9))
      0:       return '0;
      1:       return (efrs_pkg::NEED_W)'($urandom_range(0, 16'hFFFF));
      default: return (efrs_pkg::NEED_W)'($urandom_range(16'h0020, 16'h0300));
    endcase
  endfunction

  function automatic logic [efrs_pkg::DUR_W-1:0] pick_dur();
    case ($urandom_range(9))
      0:       return '0;
      1:       return (efrs_pkg::DUR_W)'($urandom_range(0, 255));
      default: return (efrs_pkg::DUR_W)'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [efrs_pkg::CAP_W-1:0] pick_cap();
    if ($urandom_range(9) == 0) return (efrs_pkg::CAP_W)'($urandom_range(0, 16'hFFFF));
    return (efrs_pkg::CAP_W)'($urandom_range(16'h0100, 16'h0600));
  endfunction

  function automatic logic [efrs_pkg::IDX_W-1:0] pick_idx();
    return (efrs_pkg::IDX_W)'($urandom_range(0, 255));
  endfunction

  // Hold the request until taken; called and returning at a rising edge
  task automatic send_req(input logic func, input logic [efrs_pkg::IN_TDATA_W-1:0] d);
    while (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= d;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // Unused fields carry random noise
  task automatic write_capacity(input logic [efrs_pkg::IDX_W-1:0] idx,
                                input logic [efrs_pkg::CAP_W-1:0] cap);
    send_req(efrs_pkg::FUNC_CAP,
             pack_req(idx, cap, (efrs_pkg::NEED_W)'($urandom_range(0, 16'hFFFF)),
                      (efrs_pkg::DUR_W)'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
  endtask

  task automatic submit_job(input logic [efrs_pkg::NEED_W-1:0] need,
                            input logic [efrs_pkg::DUR_W-1:0] dur, input logic first);
    send_req(efrs_pkg::FUNC_JOB,
             pack_req(pick_idx(), (efrs_pkg::CAP_W)'($urandom_range(0, 16'hFFFF)),
                      need, dur, first));
  endtask

  initial begin : stimulus
    int sent;
    int jobs;
    int k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every capacity entry is written before any search can read it
    for (k = 0; k < PERIODS; k++) begin
      if (k == 3)           write_capacity((efrs_pkg::IDX_W)'(k), 16'h0000);
      else if (k == 7)      write_capacity((efrs_pkg::IDX_W)'(k), 16'hFFFF);
      else if (k == 255)    write_capacity((efrs_pkg::IDX_W)'(k), 16'h0200);
      else if (k % 16 == 5) write_capacity((efrs_pkg::IDX_W)'(k),
                                           (efrs_pkg::CAP_W)'($urandom_range(0, 16'hFFFF)));
      else                  write_capacity((efrs_pkg::IDX_W)'(k), pick_cap());
    end

    // full-size first job, then searches against a saturated profile
    submit_job(16'hFFFF, 8'd255, 1'b1);
    submit_job(16'h0000, 8'd0, 1'b0);
    submit_job(16'hFFFF, 8'd9, 1'b0);
    // last period alone fits; booking runs past the profile end
    write_capacity(8'd255, 16'hFFFF);
    submit_job(16'hFFFF, 8'd3, 1'b0);
    submit_job(16'h0001, 8'd0, 1'b1);
    // zero capacity with zero need: fit at equality
    write_capacity(8'd0, 16'h0000);
    submit_job(16'h0000, 8'd5, 1'b0);
    submit_job(16'h0100, 8'd255, 1'b0);
    submit_job(16'h0080, 8'd255, 1'b0);
    write_capacity(8'd0, 16'h0400);
    submit_job(16'h0000, 8'd0, 1'b0);
    submit_job(16'hFFFF, 8'd0, 1'b0);
    submit_job(16'h00AA, 8'h55, 1'b0);
    submit_job(16'h5555, 8'hAA, 1'b0);
    submit_job(16'h0000, 8'd0, 1'b1);
    submit_job(16'hAAAA, 8'h01, 1'b0);
    write_capacity(8'd255, 16'h0200);

    sent = 0;
    while (sent < 230) begin
      calm <= (sent >= 60 && sent < 140);
      if ($urandom_range(99) < 90) begin
        submit_job(pick_need(), pick_dur(), 1'b1);
        sent++;
        jobs = int'($urandom_range(3, 12));
        for (k = 0; k < jobs; k++) begin
          if ($urandom_range(9) == 0) write_capacity(pick_idx(), pick_cap());
          else                        submit_job(pick_need(), pick_dur(), 1'b0);
          sent++;
        end
      end else begin
        // noise: any request type with any field values
        if ($urandom_range(1) == 0) begin
          write_capacity(pick_idx(), (efrs_pkg::CAP_W)'($urandom_range(0, 16'hFFFF)));
        end else begin
          submit_job((efrs_pkg::NEED_W)'($urandom_range(0, 16'hFFFF)),
                     (efrs_pkg::DUR_W)'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    calm      <= 1'b0;
    do @(negedge clk); while (awaiting != 0);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/efrs_pkg.sv
src/efrs_ctrl.sv
src/efrs_dp.sv
src/earliest_fit_resource_scheduler_unit.sv
verif/scheduler_checker.sv
verif/testbench.sv
